[rtl/core/ffha_pkg.sv]
// ============================================================================
// ffha_pkg : shared types and constants of the handle allocator
// widths, operation and status codes, register map and result layout
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    // field widths
    localparam int HANDLE_W = 14;
    localparam int REL_W    = 15;
    localparam int CNT_W    = 15;
    localparam int MIN_W    = 14;
    localparam int MAX_W    = 15;
    // candidate handle: base plus counter, one bit of growth
    localparam int CAND_W   = CNT_W + 1;

    // freed-mark store covers every handle value
    localparam int MARK_DEPTH = 1 << HANDLE_W;

    // default depth of the reuse queue
    localparam int QUEUE_DEPTH_DEF = 16384;

    // constants
    localparam logic [CNT_W-1:0]    CNT_MAX       = '1;
    localparam logic [MAX_W-1:0]    MAX_LIMIT_RST = 15'd10000;
    localparam logic [MIN_W-1:0]    MIN_BASE_RST  = '0;
    localparam logic [HANDLE_W-1:0] HANDLE_NONE   = '1;

    // configuration port
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_BIT = 2;

    typedef enum logic {
        REG_MIN_BASE  = 1'b0,
        REG_MAX_LIMIT = 1'b1
    } t_reg_idx;

    // operation codes
    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_QUERY = 2'd3
    } t_func;

    // status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    // configuration registers as seen by the controller
    typedef struct packed {
        logic [MAX_W-1:0] max_limit;
        logic [MIN_W-1:0] min_base;
    } t_cfg;

    // result beat, handle_out in the lowest bits
    typedef struct packed {
        logic                    was_used;
        logic                    is_free;
        t_status                 status;
        logic signed [REL_W-1:0] relative_index;
        logic [HANDLE_W-1:0]     handle_out;
    } t_result;

    localparam int RES_W   = $bits(t_result);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ((HANDLE_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[rtl/core/ffha_ram.sv]
// ============================================================================
// ffha_ram : simple dual-port synchronous ram
// one write port, one read port with registered read data
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ffha_cfg.sv]
// ============================================================================
// ffha_cfg : configuration registers
// apb write and read of min_base and max_limit
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ffha_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffha_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ffha_pkg::APB_DW-1:0]   pwdata,
    output      logic [ffha_pkg::APB_DW-1:0]   prdata,
    output      logic                          pready,
    output      ffha_pkg::t_cfg                o_cfg
);

    logic [ffha_pkg::MIN_W-1:0] r_min_base;
    logic [ffha_pkg::MAX_W-1:0] r_max_limit;
    logic                       wr_en;
    ffha_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = ffha_pkg::t_reg_idx'(paddr[ffha_pkg::REG_IDX_BIT]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_base  <= ffha_pkg::MIN_BASE_RST;
            r_max_limit <= ffha_pkg::MAX_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                ffha_pkg::REG_MIN_BASE:  r_min_base  <= pwdata[ffha_pkg::MIN_W-1:0];
                ffha_pkg::REG_MAX_LIMIT: r_max_limit <= pwdata[ffha_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        case (reg_idx)
            ffha_pkg::REG_MIN_BASE:  prdata = ffha_pkg::APB_DW'(r_min_base);
            ffha_pkg::REG_MAX_LIMIT: prdata = ffha_pkg::APB_DW'(r_max_limit);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.min_base  = r_min_base;
    assign o_cfg.max_limit = r_max_limit;

endmodule

`default_nettype wire

[rtl/core/ffha_ctrl.sv]
// ============================================================================
// ffha_ctrl : allocator sequencer
// reads queue and mark memories, evaluates the operation, writes back
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl #(
    parameter int QUEUE_DEPTH = ffha_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ffha_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_s_valid,
    output      logic                            o_s_ready,
    input  wire ffha_pkg::t_func                 i_func,
    input  wire logic [ffha_pkg::HANDLE_W-1:0]   i_handle,
    output      logic                            o_m_valid,
    input  wire logic                            i_m_ready,
    output      ffha_pkg::t_result               o_result
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int S_W  = QA_W + 1;
    localparam int HW   = ffha_pkg::HANDLE_W;
    localparam int CW   = ffha_pkg::CAND_W;
    localparam int NW   = ffha_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    // control state
    t_state              r_state,   n_state;
    logic [HW-1:0]       r_sweep,   n_sweep;
    logic [QA_W-1:0]     r_head,    n_head;
    logic [QC_W-1:0]     r_count,   n_count;
    logic [NW-1:0]       r_fresh,   n_fresh;
    logic [NW-1:0]       r_last,    n_last;
    logic                r_m_valid, n_m_valid;
    // item and result payload
    ffha_pkg::t_func     r_func,    n_func;
    logic [HW-1:0]       r_h,       n_h;
    ffha_pkg::t_result   r_res,     n_res;

    // memory ports
    logic                q_we;
    logic [QA_W-1:0]     q_waddr;
    logic [HW-1:0]       q_rdata;
    logic                mk_we;
    logic [HW-1:0]       mk_waddr;
    logic                mk_wdata;
    logic                mk_rdata;
    logic                accept;

    // evaluation terms
    logic                exec_go;
    logic                have_q;
    logic [CW-1:0]       base_plus;
    logic [CW-1:0]       cand;
    logic                exhausted;
    logic                free_ok;
    logic [S_W-1:0]      tail_sum;
    logic [S_W-1:0]      tail;
    logic [S_W-1:0]      head_sum;
    logic [HW-1:0]       hout;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_m_valid;
    assign o_result  = r_res;

    // reuse queue: read at head on accept, written at tail on a good free
    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (r_h),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // freed marks: read at the handle on accept, swept to zero after clear
    ffha_ram #(
        .WIDTH (1),
        .DEPTH (ffha_pkg::MARK_DEPTH)
    ) u_mark (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_waddr),
        .i_wdata (mk_wdata),
        .i_re    (accept),
        .i_raddr (i_handle),
        .o_rdata (mk_rdata)
    );

    // evaluation of the held item against memory read data
    always_comb begin
        exec_go   = (r_state == S_EXEC) && (!r_m_valid || i_m_ready);
        have_q    = (r_count != '0);
        base_plus = CW'(i_cfg.min_base) + CW'(r_fresh);
        cand      = have_q ? CW'(q_rdata) : base_plus;
        exhausted = (cand >= CW'(i_cfg.max_limit));
        free_ok   = (CW'(r_h) < base_plus)
                    && (CW'(r_h) < CW'(i_cfg.max_limit))
                    && !mk_rdata
                    && (r_count < QC_W'(QUEUE_DEPTH));
        tail_sum  = S_W'(r_head) + S_W'(r_count);
        tail      = (tail_sum >= S_W'(QUEUE_DEPTH)) ? tail_sum - S_W'(QUEUE_DEPTH)
                                                     : tail_sum;
        head_sum  = S_W'(r_head) + S_W'(1);
    end

    // next state, write-back and result
    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_head    = r_head;
        n_count   = r_count;
        n_fresh   = r_fresh;
        n_last    = r_last;
        n_m_valid = r_m_valid;
        n_func    = r_func;
        n_h       = r_h;
        n_res     = r_res;
        q_we      = 1'b0;
        q_waddr   = tail[QA_W-1:0];
        mk_we     = 1'b0;
        mk_waddr  = r_h;
        mk_wdata  = 1'b0;
        hout      = r_h;

        // result taken downstream
        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            // clear every freed mark, one entry a cycle
            S_SWEEP: begin
                mk_we    = 1'b1;
                mk_waddr = r_sweep;
                n_sweep  = r_sweep + HW'(1);
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end

            // take an item, memory reads are issued this cycle
            S_IDLE: begin
                if (accept) begin
                    n_func  = i_func;
                    n_h     = i_handle;
                    n_state = S_EXEC;
                end
            end

            // evaluate and commit once the output register is free
            S_EXEC: begin
                if (exec_go) begin
                    n_state                  = S_IDLE;
                    n_m_valid                = 1'b1;
                    n_res.status             = ffha_pkg::ST_OK;
                    n_res.is_free            = 1'b0;
                    n_res.was_used           = 1'b0;
                    case (r_func)
                        ffha_pkg::FN_ALLOC: begin
                            if (have_q) begin
                                mk_we    = 1'b1;
                                mk_waddr = q_rdata;
                                n_head   = (head_sum >= S_W'(QUEUE_DEPTH)) ? '0
                                                                          : head_sum[QA_W-1:0];
                                n_count  = r_count - QC_W'(1);
                            end else if (r_fresh < ffha_pkg::CNT_MAX) begin
                                n_fresh  = r_fresh + NW'(1);
                            end
                            n_last = (cand > CW'(ffha_pkg::CNT_MAX)) ? ffha_pkg::CNT_MAX
                                                                      : cand[NW-1:0];
                            hout   = cand[HW-1:0];
                            if (exhausted) begin
                                n_res.status = ffha_pkg::ST_EXHAUSTED;
                            end
                        end
                        ffha_pkg::FN_FREE: begin
                            if (free_ok) begin
                                q_we     = 1'b1;
                                mk_we    = 1'b1;
                                mk_wdata = 1'b1;
                                n_count  = r_count + QC_W'(1);
                            end else begin
                                n_res.status = ffha_pkg::ST_INVALID;
                            end
                        end
                        ffha_pkg::FN_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                            n_fresh = '0;
                            n_last  = '0;
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_res.is_free  = mk_rdata;
                            n_res.was_used = (NW'(r_h) < r_last);
                        end
                    endcase
                    if ((r_func == ffha_pkg::FN_ALLOC) && exhausted) begin
                        n_res.handle_out     = ffha_pkg::HANDLE_NONE;
                        n_res.relative_index = '0;
                    end else begin
                        n_res.handle_out     = hout;
                        n_res.relative_index = ffha_pkg::REL_W'(hout)
                                               - ffha_pkg::REL_W'(i_cfg.min_base);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_sweep   <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_fresh   <= '0;
            r_last    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sweep   <= n_sweep;
            r_head    <= n_head;
            r_count   <= n_count;
            r_fresh   <= n_fresh;
            r_last    <= n_last;
            r_m_valid <= n_m_valid;
        end
        r_func <= n_func;
        r_h    <= n_h;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

[rtl/core/fifo_free_list_handle_allocator.sv]
// ============================================================================
// fifo_free_list_handle_allocator : handle allocator with fifo reuse
// allocate, free, clear and query of handles; freed handles reused oldest first
// ============================================================================
//  channel   dir  beat contents
//  s_axis    in   tuser: func; tdata: handle_in
//  m_axis    out  tdata: handle_out, relative_index, status, is_free, was_used
//  apb       in   min_base at 0x0, max_limit at 0x4
//
//  for each item, the accept cycle addresses the queue and mark memories,
//  and the exec state then evaluates the read data and writes back.
//  after reset and after a clear operation the mark memory is swept to zero,
//  one entry a cycle, with s_axis_tready low.
//  the result sits in an output register; a new item is taken while it waits,
//  and evaluation holds until that register is free.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fifo_free_list_handle_allocator #(
    parameter int QUEUE_DEPTH = ffha_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // [1:0] func
    input  wire logic [1:0]                       s_axis_tuser,
    // [13:0] handle_in
    input  wire logic [ffha_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // [13:0] handle_out, [28:14] relative_index, [30:29] status,
    // [31] is_free, [32] was_used
    output      logic [ffha_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ffha_pkg::APB_AW-1:0]      paddr,
    input  wire logic [ffha_pkg::APB_DW-1:0]      pwdata,
    output      logic [ffha_pkg::APB_DW-1:0]      prdata,
    output      logic                             pready
);

    ffha_pkg::t_cfg    cfg;
    ffha_pkg::t_result result;

    // configuration registers
    ffha_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer with queue and mark memories
    ffha_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_func    (ffha_pkg::t_func'(s_axis_tuser)),
        .i_handle  (s_axis_tdata[ffha_pkg::HANDLE_W-1:0]),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_result  (result)
    );

    // result beat, zero padded to whole bytes
    assign m_axis_tdata = ffha_pkg::M_TDATA_W'(result);

endmodule

`default_nettype wire
